/* rtl/core/vfpt_pkg.sv */
`timescale 1ns / 1ps
// vfpt_pkg: types, phase codes and timing constants of the frame phase timer
// no dependencies; used by vfpt_step and video_frame_phase_timer

package vfpt_pkg;

	// phase numbers with their own behavior
	localparam logic [3:0] PH_VBLANK = 4'd0;
	localparam logic [3:0] PH_ENABLE = 4'd1;
	localparam logic [3:0] PH_FIRST  = 4'd2;
	localparam logic [3:0] PH_LAST   = 4'd14;
	localparam logic [3:0] PH_TAIL   = 4'd15;
	localparam logic [3:0] PH_RESET  = PH_TAIL;

	// phase lengths in cpu cycles
	localparam int VBLANK_LEN  = 2900;
	localparam int ENABLE_LEN  = 3796 - VBLANK_LEN;
	localparam int ROW_LEN     = 912;
	localparam int ROW_STEP    = 114;
	localparam int FIRST_BASE  = 120;
	localparam int TAIL_LEN    = 57 + 17;
	localparam int INTR_MAX    = 4095;

	// bus request stall lengths
	localparam logic [6:0] STALL_NONE  = 7'd0;
	localparam logic [6:0] STALL_FIRST = 7'd68;
	localparam logic [6:0] STALL_ROW   = 7'd108;
	localparam logic [6:0] STALL_TAIL  = 7'd38;

	typedef struct packed {
		logic [5:0] cpu_cycles;
		logic       display_enable_write;
		logic [2:0] vertical_delay;
		logic [2:0] horizontal_delay;
	} vfpt_in_t;

	typedef struct packed {
		logic [3:0]  phase;
		logic [15:0] countdown;
		logic [11:0] intr;
		logic        latch;
		logic        pend;
		logic        reg_acc;
		logic        gram_acc;
	} vfpt_state_t;

	typedef struct packed {
		logic       keep_running;
		logic       halted;
		logic       frame_start;
		logic       render_enable;
		logic       registers_accessible;
		logic       gram_accessible;
		logic       interrupt_active;
		logic [6:0] stall_cycles;
		logic [3:0] current_phase;
	} vfpt_res_t;

endpackage

/* rtl/core/video_frame_phase_timer.sv */
`timescale 1ns / 1ps
// video_frame_phase_timer: frame phase sequencer of a video chip
// depends on vfpt_pkg and vfpt_step
//
// channel | signals                                   | direction
// --------+-------------------------------------------+----------
// in      | in_valid, in_stall, cpu_cycles, ...delay   | into block
// out     | out_valid, out_stall, keep_running, ...    | out of block
//
// one item per clock while the result is not stalled; an accepted item passes
// the input register, then step logic into the result register.
// reset restores phase 15, zero countdowns and both access flags set.
// a stalled result register holds the input register too; in_stall rises
// only when both are full and out_stall is high.

module video_frame_phase_timer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [5:0] cpu_cycles,
	input  logic       display_enable_write,
	input  logic [2:0] vertical_delay,
	input  logic [2:0] horizontal_delay,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       keep_running,
	output logic       halted,
	output logic       frame_start,
	output logic       render_enable,
	output logic       registers_accessible,
	output logic       gram_accessible,
	output logic       interrupt_active,
	output logic [6:0] stall_cycles,
	output logic [3:0] current_phase
);
	import vfpt_pkg::*;

	vfpt_in_t    item_s1;
	logic        valid_s1;
	vfpt_state_t state_q;
	vfpt_state_t state_nxt;
	vfpt_res_t   res_nxt;
	vfpt_res_t   res_q;
	logic        out_valid_q;
	logic        out_free;
	logic        fire_s2;
	logic        take_in;

	// handshake
	assign out_free = !out_valid_q || !out_stall;
	assign fire_s2  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign take_in  = in_valid && !in_stall;

	// step logic
	vfpt_step u_step (
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// control and timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1          <= 1'b0;
			out_valid_q       <= 1'b0;
			state_q.phase     <= PH_RESET;
			state_q.countdown <= '0;
			state_q.intr      <= '0;
			state_q.latch     <= 1'b0;
			state_q.pend      <= 1'b0;
			state_q.reg_acc   <= 1'b1;
			state_q.gram_acc  <= 1'b1;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (out_free)
				out_valid_q <= valid_s1;
			if (fire_s2)
				state_q <= state_nxt;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.cpu_cycles           <= cpu_cycles;
			item_s1.display_enable_write <= display_enable_write;
			item_s1.vertical_delay       <= vertical_delay;
			item_s1.horizontal_delay     <= horizontal_delay;
		end
		if (fire_s2)
			res_q <= res_nxt;
	end

	// result ports
	assign out_valid            = out_valid_q;
	assign keep_running         = res_q.keep_running;
	assign halted               = res_q.halted;
	assign frame_start          = res_q.frame_start;
	assign render_enable        = res_q.render_enable;
	assign registers_accessible = res_q.registers_accessible;
	assign gram_accessible      = res_q.gram_accessible;
	assign interrupt_active     = res_q.interrupt_active;
	assign stall_cycles         = res_q.stall_cycles;
	assign current_phase        = res_q.current_phase;

	// state moves only with an item
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s2 |=> $stable(state_q))
		else $error("timer state changed without an item");

	// a halt leaves the state alone
	a_halt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s2 && item_s1.cpu_cycles == 6'd0) |=> $stable(state_q))
		else $error("halt item changed timer state");

	// frame start lands on phase 0 with both access flags set
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.frame_start) |->
		(res_q.current_phase == PH_VBLANK && res_q.registers_accessible &&
		res_q.gram_accessible && !res_q.keep_running))
		else $error("frame start with wrong phase or flags");

	// input stalls only behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

endmodule

/* rtl/core/vfpt_step.sv */
`timescale 1ns / 1ps
// vfpt_step: next state and result of the frame timer for one item
// depends on vfpt_pkg

module vfpt_step (
	input  vfpt_pkg::vfpt_in_t    item,
	input  vfpt_pkg::vfpt_state_t cur,
	output vfpt_pkg::vfpt_state_t nxt,
	output vfpt_pkg::vfpt_res_t   res
);
	import vfpt_pkg::*;

	logic [9:0]  dly;
	logic [17:0] len_a;
	logic [17:0] len_v;
	logic [17:0] add;
	logic [17:0] len_f;
	logic [6:0]  stall;
	logic [3:0]  ph;
	logic        halt;
	logic        start;

	// scroll delay term shared by first and last row phases
	assign dly = 10'(10'(ROW_STEP) * {7'd0, item.vertical_delay}) +
		{7'd0, item.horizontal_delay};

	// countdown minus this item's cycles, sign in bit 17
	assign len_a = {{2{cur.countdown[15]}}, cur.countdown} - {12'd0, item.cpu_cycles};
	assign len_v = len_a + 18'(VBLANK_LEN);
	assign ph    = cur.phase + 4'd1;
	assign halt  = (item.cpu_cycles == 6'd0);

	always_comb begin
		nxt   = cur;
		add   = '0;
		stall = STALL_NONE;
		start = 1'b0;
		len_f = len_a;
		if (!halt) begin
			if (item.display_enable_write)
				nxt.pend = 1'b1;
			// vblank interrupt countdown stops at zero
			if (cur.intr != 12'd0) begin
				if (cur.intr > {6'd0, item.cpu_cycles})
					nxt.intr = cur.intr - {6'd0, item.cpu_cycles};
				else
					nxt.intr = 12'd0;
			end
			// phase advance when the countdown runs out
			if (len_a[17]) begin
				nxt.phase = ph;
				case (ph)
					PH_VBLANK: begin
						start        = 1'b1;
						nxt.reg_acc  = 1'b1;
						nxt.gram_acc = 1'b1;
						nxt.pend     = 1'b0;
						if (len_v[17])
							nxt.intr = 12'd0;
						else if (|len_v[16:12])
							nxt.intr = 12'(INTR_MAX);
						else
							nxt.intr = len_v[11:0];
					end
					PH_ENABLE: begin
						add          = 18'(ENABLE_LEN);
						nxt.latch    = nxt.pend;
						nxt.gram_acc = 1'b1;
						if (nxt.pend)
							nxt.reg_acc = 1'b0;
					end
					PH_FIRST: begin
						add = 18'(FIRST_BASE) + {8'd0, dly};
						if (cur.latch) begin
							nxt.gram_acc = 1'b0;
							stall        = STALL_FIRST;
						end
					end
					PH_LAST: begin
						add = 18'(ROW_LEN) - {8'd0, dly};
						if (cur.latch)
							stall = STALL_ROW;
					end
					PH_TAIL: begin
						add = 18'(TAIL_LEN);
						if (cur.latch && item.vertical_delay == 3'd0)
							stall = STALL_TAIL;
					end
					default: begin
						add = 18'(ROW_LEN);
						if (cur.latch)
							stall = STALL_ROW;
					end
				endcase
				len_f = start ? len_v : (len_a + add - {11'd0, stall});
			end
			nxt.countdown = len_f[15:0];
		end
	end

	// result shows the state after the step
	always_comb begin
		res.keep_running         = !halt && !start;
		res.halted               = halt;
		res.frame_start          = start;
		res.render_enable        = nxt.latch;
		res.registers_accessible = nxt.reg_acc;
		res.gram_accessible      = nxt.gram_acc;
		res.interrupt_active     = (nxt.intr != 12'd0);
		res.stall_cycles         = stall;
		res.current_phase        = nxt.phase;
	end

endmodule
